[sv/kpc_pkg.sv]
// Package for the dual key press classifier.
// Holds shared constants, event codes and the per-key event struct.
// No dependencies.
package kpc_pkg;

  // Default timestamp width kept in the per-key state
  localparam int unsigned TICK_BITS_DEF = 32;

  // Width of the scan item timestamp field
  localparam int unsigned NOW_W = 32;

  // Configuration register layout
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 1'b0,
    CFG_LONG     = 1'b1
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;

  // Result codes
  localparam int unsigned EVT_W = 3;

  typedef enum logic [EVT_W-1:0] {
    EVT_NONE       = 3'd0,
    EVT_KEY1_SHORT = 3'd1,
    EVT_KEY1_LONG  = 3'd2,
    EVT_KEY2_SHORT = 3'd3,
    EVT_KEY2_LONG  = 3'd4
  } evt_code_e;

  // Thresholds handed to each key scanner
  typedef struct packed {
    logic [CFG_W-1:0] debounce;
    logic [CFG_W-1:0] long_press;
  } kpc_cfg_t;

  // Events raised by one key scanner for the staged item
  typedef struct packed {
    logic short_ev;
    logic long_ev;
  } kpc_evt_t;

endpackage

[sv/kpc_key.sv]
// Per-key state and press classification for the dual key press classifier.
// Evaluates one staged scan item and updates its state on commit.
// Depends on kpc_pkg.
module kpc_key #(
  parameter int unsigned TICK_BITS = kpc_pkg::TICK_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 commit_i,
  input  logic                 pressed_i,
  input  logic [TICK_BITS-1:0] now_i,
  input  kpc_pkg::kpc_cfg_t    cfg_i,
  output kpc_pkg::kpc_evt_t    evt_o
);
  import kpc_pkg::*;

  logic                 released_q, released_d;
  logic [TICK_BITS-1:0] start_q, start_d;
  logic                 long_done_q, long_done_d;
  logic                 armed_q, armed_d;

  logic [TICK_BITS-1:0] elapsed;
  logic                 past_debounce;
  logic                 past_long;
  logic                 changed;

  // Elapsed time wraps modulo 2^TICK_BITS
  assign elapsed       = now_i - start_q;
  assign past_debounce = elapsed >= TICK_BITS'(cfg_i.debounce);
  assign past_long     = elapsed >= TICK_BITS'(cfg_i.long_press);
  assign changed       = (pressed_i == released_q);

  // Classification and next state
  always_comb begin
    released_d  = released_q;
    start_d     = start_q;
    long_done_d = long_done_q;
    armed_d     = armed_q;
    evt_o       = '0;
    if (changed) begin
      if (pressed_i) begin
        // new press: record start, arm short detection
        start_d     = now_i;
        long_done_d = 1'b0;
        armed_d     = 1'b1;
        released_d  = 1'b0;
      end else begin
        released_d = 1'b1;
        if (armed_q && past_debounce) begin
          armed_d        = 1'b0;
          evt_o.short_ev = ~past_long;
        end
      end
    end else if (pressed_i && !long_done_q && past_long) begin
      long_done_d   = 1'b1;
      evt_o.long_ev = 1'b1;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      released_q  <= 1'b1;
      start_q     <= '0;
      long_done_q <= 1'b0;
      armed_q     <= 1'b0;
    end else if (commit_i) begin
      released_q  <= released_d;
      start_q     <= start_d;
      long_done_q <= long_done_d;
      armed_q     <= armed_d;
    end
  end

endmodule

[sv/dual_key_press_classifier_top.sv]
// Top level of the dual key press classifier: input stage, two key scanners,
// config registers and the result register.
// Depends on kpc_pkg and kpc_key.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, now_tick_i, key1/2_down | input
//  out     | out_valid_o, out_ready_i, event_code_o          | output
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i                 | input
//
// One item per cycle sustained while the result is not stalled; an accepted item
// passes through the input register, then the result register.
// The key state updates when a staged item moves into the result register,
// so the next item always sees the state left by the previous one.
// A stalled result holds both registers; in_ready_o drops only when both
// hold an item. Reset clears state to released keys and default thresholds.
module dual_key_press_classifier_top #(
  parameter int unsigned TICK_BITS = kpc_pkg::TICK_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [kpc_pkg::NOW_W-1:0] now_tick_i,
  input  logic                      key1_down_i,
  input  logic                      key2_down_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [kpc_pkg::EVT_W-1:0] event_code_o,
  input  logic                      cfg_we_i,
  input  logic [kpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kpc_pkg::CFG_W-1:0] cfg_data_i
);
  import kpc_pkg::*;

  kpc_cfg_t cfg_q;

  logic                 in_vld_q;
  logic [TICK_BITS-1:0] now_q;
  logic                 k1_q, k2_q;

  logic                 out_vld_q;
  logic [EVT_W-1:0]     evt_q, evt_d;

  logic     adv;
  logic     commit1, commit2;
  kpc_evt_t evt1, evt2;
  logic     k1_hit;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce   <= DEBOUNCE_RST;
      cfg_q.long_press <= LONG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE: cfg_q.debounce   <= cfg_data_i;
        CFG_LONG:     cfg_q.long_press <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Handshake: staged item advances when the result register frees up
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      now_q <= TICK_BITS'(now_tick_i);
      k1_q  <= key1_down_i;
      k2_q  <= key2_down_i;
    end
  end

  // Key scanners; key 2 is left alone when key 1 reports
  assign commit1 = in_vld_q && adv;
  assign k1_hit  = evt1.short_ev || evt1.long_ev;
  assign commit2 = commit1 && !k1_hit;

  kpc_key #(.TICK_BITS(TICK_BITS)) u_key1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .commit_i  (commit1),
    .pressed_i (k1_q),
    .now_i     (now_q),
    .cfg_i     (cfg_q),
    .evt_o     (evt1)
  );

  kpc_key #(.TICK_BITS(TICK_BITS)) u_key2 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .commit_i  (commit2),
    .pressed_i (k2_q),
    .now_i     (now_q),
    .cfg_i     (cfg_q),
    .evt_o     (evt2)
  );

  // Event code, key 1 first
  always_comb begin
    priority if (evt1.short_ev) begin
      evt_d = EVT_KEY1_SHORT;
    end else if (evt1.long_ev) begin
      evt_d = EVT_KEY1_LONG;
    end else if (evt2.short_ev) begin
      evt_d = EVT_KEY2_SHORT;
    end else if (evt2.long_ev) begin
      evt_d = EVT_KEY2_LONG;
    end else begin
      evt_d = EVT_NONE;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit1) begin
      evt_q <= evt_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign event_code_o = evt_q;

endmodule

[sv/kpc_checker.sv]
// Port-level checker for the dual key press classifier, bound to the top.
// Watches the handshakes and the result codes over time.
// Depends on kpc_pkg.
module kpc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [kpc_pkg::EVT_W-1:0]     event_code_o
);
  import kpc_pkg::*;

  // A stalled result holds its code
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_code_o))
    else $error("result changed while stalled");

  // Codes stay within the defined set
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> event_code_o <= EVT_KEY2_LONG)
    else $error("undefined event code");

  // Input side is never blocked while the output side can move
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input blocked with free output");

  // A fresh result follows an item accepted into the input register
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without an accepted item");

endmodule

bind dual_key_press_classifier_top kpc_checker u_kpc_checker (.*);

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for dual_key_press_classifier_top: drives scan items,
// predicts the short and long press events of both keys and checks each result.
// Depends on kpc_pkg and the classifier RTL.
module testbench;
  import kpc_pkg::*;

  localparam int unsigned TICK_W     = TICK_BITS_DEF;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned SETTLE     = 4;
  localparam int unsigned HOLD_OFF   = 80;
  localparam int unsigned MAX_REPORT = 10;

  typedef struct packed {
    logic [NOW_W-1:0] now;
    logic             k1;
    logic             k2;
  } scan_t;

  typedef struct {
    logic              released;
    logic [TICK_W-1:0] start;
    logic              long_done;
    logic              short_armed;
  } key_state_t;

  // DUT connections; the driven inputs are known from time zero
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [NOW_W-1:0] now_tick_i  = '0;
  logic             key1_down_i = 1'b0;
  logic             key2_down_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [EVT_W-1:0] event_code_o;
  logic             cfg_we_i    = 1'b0;
  cfg_idx_e         cfg_idx_i   = CFG_DEBOUNCE;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  // Press state and thresholds as the block should hold them
  key_state_t       key_st[2];
  logic [CFG_W-1:0] debounce_ticks;
  logic [CFG_W-1:0] long_ticks;

  // Scan items waiting to be sent, events waiting to come out
  scan_t            pending_scans[$];
  evt_code_e        expected_events[$];
  scan_t            next_scan;
  logic             scan_taken = 1'b0;

  // Idling controls
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  logic             hold_off_req   = 1'b0;
  int unsigned      hold_left      = 0;

  // Stimulus shaping: running tick, key levels and press ticks
  logic [NOW_W-1:0] gen_tick;
  logic             gen_level[2];
  logic [NOW_W-1:0] gen_press[2];

  // Bookkeeping
  int unsigned      err_count   = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      scans_in    = 0;
  int unsigned      results_out = 0;
  int unsigned      cfg_writes  = 0;
  int unsigned      evt_hits[5];

  dual_key_press_classifier_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .now_tick_i   (now_tick_i),
    .key1_down_i  (key1_down_i),
    .key2_down_i  (key2_down_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_code_o (event_code_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // One key: level change, short press on release, long press while held
  function automatic evt_code_e scan_key(int unsigned idx, logic pressed,
                                         logic [TICK_W-1:0] now,
                                         evt_code_e ev_short, evt_code_e ev_long);
    logic [TICK_W-1:0] elapsed;
    evt_code_e         ev;
    elapsed = now - key_st[idx].start;
    ev      = EVT_NONE;
    if (pressed == key_st[idx].released) begin
      if (pressed) begin
        key_st[idx].start       = now;
        key_st[idx].long_done   = 1'b0;
        key_st[idx].short_armed = 1'b1;
        key_st[idx].released    = 1'b0;
      end else begin
        key_st[idx].released = 1'b1;
        // too early a release keeps the short flag armed
        if (key_st[idx].short_armed && elapsed >= debounce_ticks) begin
          key_st[idx].short_armed = 1'b0;
          if (elapsed < long_ticks) ev = ev_short;
        end
      end
    end else if (pressed && !key_st[idx].long_done && elapsed >= long_ticks) begin
      key_st[idx].long_done = 1'b1;
      ev = ev_long;
    end
    return ev;
  endfunction

  // Key 1 first; key 2 only looked at when key 1 stays quiet
  function automatic evt_code_e classify_scan(logic [NOW_W-1:0] now, logic k1,
                                              logic k2);
    evt_code_e ev;
    ev = scan_key(0, k1, TICK_W'(now), EVT_KEY1_SHORT, EVT_KEY1_LONG);
    if (ev == EVT_NONE) ev = scan_key(1, k2, TICK_W'(now), EVT_KEY2_SHORT, EVT_KEY2_LONG);
    return ev;
  endfunction

  // Random scan: ticks creep, land near the thresholds of a press, or jump anywhere
  function automatic scan_t make_scan();
    scan_t       s;
    int unsigned k;
    int unsigned mode;
    k    = $urandom_range(0, 1);
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2, 3: gen_tick = gen_tick + $urandom_range(0, 3);
      4, 5:       gen_tick = gen_press[k] + debounce_ticks + $urandom_range(0, 2) - 1;
      6, 7:       gen_tick = gen_press[k] + long_ticks + $urandom_range(0, 2) - 1;
      8:          gen_tick = gen_tick + $urandom_range(0, 2 * long_ticks + 2);
      default:    gen_tick = $urandom;
    endcase
    for (int i = 0; i < 2; i++) begin
      if ($urandom_range(0, 99) < 30) begin
        gen_level[i] = !gen_level[i];
        if (gen_level[i]) gen_press[i] = gen_tick;
      end
    end
    s.now = gen_tick;
    s.k1  = gen_level[0];
    s.k2  = gen_level[1];
    return s;
  endfunction

  function automatic void push_scan(logic [NOW_W-1:0] now, logic k1, logic k2);
    scan_t s;
    s.now = now;
    s.k1  = k1;
    s.k2  = k2;
    pending_scans.push_back(s);
  endfunction

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORT) $display("ERROR: %s", msg);
  endfunction

  // Wait until every queued item went in and every event came out
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_scans.size() != 0 || in_valid_i || expected_events.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DEBOUNCE) debounce_ticks = val;
    else long_ticks = val;
    cfg_writes++;
  endtask

  // One threshold setting with its own idling mix
  task automatic run_phase(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] lng,
                           int unsigned idle_pct, int unsigned stall_pct,
                           int unsigned n, bit hold, bit pause);
    wait_drained();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_cfg(CFG_DEBOUNCE, deb);
    write_cfg(CFG_LONG, lng);
    @(posedge clk_i);
    for (int unsigned i = 0; i < n; i++) begin
      // sender goes quiet until the block is empty
      if (pause && i == n / 2) wait_drained();
      pending_scans.push_back(make_scan());
    end
    if (hold) begin
      repeat (20) @(posedge clk_i);
      hold_off_req = 1'b1;
    end
  endtask

  // Sender: next item offered on the falling edge, held until taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || scan_taken) begin
      scan_taken = 1'b0;
      if (pending_scans.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_scan = pending_scans.pop_front();
        in_valid_i  <= 1'b1;
        now_tick_i  <= next_scan.now;
        key1_down_i <= next_scan.k1;
        key2_down_i <= next_scan.k2;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_off_req) begin
        hold_left    = HOLD_OFF;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Monitor: predict on input handshakes, check on output handshakes
  always @(posedge clk_i) begin : monitor
    evt_code_e exp_ev;
    logic      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && in_ready_o) begin
        expected_events.push_back(classify_scan(now_tick_i, key1_down_i, key2_down_i));
        scan_taken = 1'b1;
        scans_in++;
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        results_out++;
        if (expected_events.size() == 0) begin
          note_error($sformatf("result %0d (code %0d) with no item pending",
                               results_out, event_code_o));
        end else begin
          exp_ev = expected_events.pop_front();
          if (event_code_o !== exp_ev)
            note_error($sformatf("result %0d: expected %s (%0d), got %0d", results_out,
                                 exp_ev.name(), exp_ev, event_code_o));
          else
            evt_hits[int'(exp_ev)]++;
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: nothing moving for too long ends the run
  initial begin
    @(posedge rst_ni);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("Watchdog: no handshake for %0d cycles, %0d events outstanding",
             IDLE_LIMIT, expected_events.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence
  initial begin
    logic [NOW_W-1:0] t0;
    for (int i = 0; i < 2; i++) begin
      key_st[i].released    = 1'b1;
      key_st[i].start       = '0;
      key_st[i].long_done   = 1'b0;
      key_st[i].short_armed = 1'b0;
      gen_level[i]          = 1'b0;
      gen_press[i]          = '0;
      evt_hits[i]           = 0;
    end
    for (int i = 2; i < 5; i++) evt_hits[i] = 0;
    debounce_ticks = DEBOUNCE_RST;
    long_ticks     = LONG_RST;
    gen_tick       = 32'hFFFF_F000;
    t0             = 32'hFFFF_FF00;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset thresholds: early release, exact debounce, key 1 priority,
    // release after long, just-short key 2, tick wrap
    push_scan(t0, 1'b0, 1'b0);
    push_scan(t0, 1'b1, 1'b0);
    push_scan(t0 + 10, 1'b0, 1'b0);
    push_scan(t0 + 11, 1'b1, 1'b0);
    push_scan(t0 + 31, 1'b0, 1'b0);
    push_scan(t0 + 40, 1'b1, 1'b1);
    push_scan(t0 + 1040, 1'b1, 1'b1);
    push_scan(t0 + 1041, 1'b1, 1'b1);
    push_scan(t0 + 1100, 1'b0, 1'b0);
    push_scan(t0 + 1200, 1'b0, 1'b1);
    push_scan(t0 + 2199, 1'b0, 1'b0);
    push_scan(t0 + 3000, 1'b1, 1'b1);
    push_scan(t0 + 3025, 1'b0, 1'b0);
    push_scan(t0 + 3030, 1'b0, 1'b0);
    push_scan(32'hFFFF_FFFF, 1'b1, 1'b0);
    push_scan(32'h0000_03E7, 1'b1, 1'b0);
    push_scan(32'h0000_03E8, 1'b0, 1'b0);
    wait_drained();

    // Zero thresholds: long on the first unchanged pressed scan, never short
    write_cfg(CFG_DEBOUNCE, '0);
    write_cfg(CFG_LONG, '0);
    @(posedge clk_i);
    push_scan(32'd5, 1'b1, 1'b1);
    push_scan(32'd5, 1'b1, 1'b1);
    push_scan(32'd5, 1'b1, 1'b1);
    push_scan(32'd6, 1'b0, 1'b0);
    push_scan(32'd6, 1'b0, 1'b1);
    push_scan(32'd7, 1'b0, 1'b0);

    // Random phases
    run_phase(DEBOUNCE_RST, LONG_RST, 0, 0, 180, 1'b0, 1'b0);
    run_phase(16'd5, 16'd40, 67, 0, 180, 1'b0, 1'b0);
    run_phase(16'd0, 16'd0, 0, 67, 180, 1'b0, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 27, 27, 180, 1'b0, 1'b0);
    run_phase(16'd0, 16'hFFFF, 0, 0, 180, 1'b1, 1'b0);
    run_phase(16'hFFFF, 16'd0, 67, 0, 180, 1'b0, 1'b0);
    run_phase(16'($urandom_range(0, 31)), 16'($urandom_range(0, 127)), 0, 67, 180,
              1'b0, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 27, 27, 190, 1'b0, 1'b1);
    wait_drained();

    $display("Sent %0d scan items over %0d register writes; %0d events checked",
             scans_in, cfg_writes, results_out);
    $display("Events: none %0d, key1 short %0d, key1 long %0d, key2 short %0d, key2 long %0d",
             evt_hits[0], evt_hits[1], evt_hits[2], evt_hits[3], evt_hits[4]);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", err_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
